// ===== rtl/core/text_console_writer_defines.svh =====
// ----------------------------------------------------------------------------
// text_console_writer_defines: assertion macros for the text console writer
// Clocked on clk and disabled while rst_n is low.
// ----------------------------------------------------------------------------
`ifndef TEXT_CONSOLE_WRITER_DEFINES_SVH
`define TEXT_CONSOLE_WRITER_DEFINES_SVH

`ifndef SYNTHESIS

// Property must hold at every clock edge out of reset.
`define TCW_ASSERT_CLK(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Expression must never be true out of reset.
`define TCW_ASSERT_NEVER(lbl, expr, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) else $error(msg);

`else

`define TCW_ASSERT_CLK(lbl, prop, msg)
`define TCW_ASSERT_NEVER(lbl, expr, msg)

`endif

`endif

// ===== rtl/core/tcw_pkg.sv =====
// ----------------------------------------------------------------------------
// tcw_pkg: shared types and constants of the text console writer
// Field widths, item kinds, character codes and sequencer states.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package tcw_pkg;

    localparam int DEF_COLUMNS = 80;
    localparam int DEF_ROWS    = 25;

    localparam int KIND_W = 2;
    localparam int CHAR_W = 8;
    localparam int ATTR_W = 8;
    localparam int COL_W  = 7;
    localparam int ROW_W  = 5;
    localparam int CELL_W = ATTR_W + CHAR_W;

    localparam logic [KIND_W-1:0] KIND_PUT    = 2'd0;
    localparam logic [KIND_W-1:0] KIND_CLEAR  = 2'd1;
    localparam logic [KIND_W-1:0] KIND_SETPOS = 2'd2;
    localparam logic [KIND_W-1:0] KIND_READ   = 2'd3;

    localparam logic [CHAR_W-1:0] CODE_LF    = 8'd10;
    localparam logic [CHAR_W-1:0] CODE_CR    = 8'd13;
    localparam logic [CHAR_W-1:0] CODE_SPACE = 8'd32;

    localparam logic [ATTR_W-1:0] RESET_ATTR = 8'h31;

    typedef enum logic [2:0] {
        ST_INIT,
        ST_IDLE,
        ST_FILL,
        ST_SCROLL,
        ST_RESULT
    } tcw_state_t;

endpackage

// ===== rtl/core/tcw_ram.sv =====
// ----------------------------------------------------------------------------
// tcw_ram: generic simple dual-port RAM
// One write port, one read port, read data registered.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tcw_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 2000
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// ===== rtl/core/text_console_writer.sv =====
// ----------------------------------------------------------------------------
// text_console_writer: text-mode character store with cursor
// ROWS x COLUMNS cells of character and attribute, with put, clear,
// set-cursor and read items and one result per item.
// ----------------------------------------------------------------------------
// The screen lives in one single-port-write RAM of ROWS*COLUMNS cells, and a
// sweep counter with its address adder does every bulk pass over it. After
// reset the block runs a clearing pass over every cell with item_stall high;
// configuration writes are taken during it. A put that stays on the screen, a
// set-cursor and a read go from the idle state to the result step, which loads
// the output register once it is free. A clear first fills every cell in a
// sweep, and a put or line break that scrolls first runs the scroll, which
// copies every row up one cell per cycle through the RAM read and write ports
// and then zeroes the bottom row. A new item is accepted while the previous
// result waits in the output register.
`timescale 1ns / 1ps

`include "text_console_writer_defines.svh"

module text_console_writer #(
    parameter int COLUMNS = tcw_pkg::DEF_COLUMNS,
    parameter int ROWS    = tcw_pkg::DEF_ROWS
) (
    input  logic                        clk,
    input  logic                        rst_n,

    input  logic                        cfg_valid,
    output logic                        cfg_ready,
    input  logic [tcw_pkg::ATTR_W-1:0]  text_attribute,

    input  logic                        item_valid,
    output logic                        item_stall,
    input  logic [tcw_pkg::KIND_W-1:0]  kind,
    input  logic [tcw_pkg::CHAR_W-1:0]  char_code,
    input  logic [tcw_pkg::COL_W-1:0]   target_col,
    input  logic [tcw_pkg::ROW_W-1:0]   target_row,

    output logic                        result_valid,
    input  logic                        result_stall,
    output logic [tcw_pkg::COL_W-1:0]   cursor_col,
    output logic [tcw_pkg::ROW_W-1:0]   cursor_row,
    output logic [tcw_pkg::CHAR_W-1:0]  cell_char,
    output logic [tcw_pkg::ATTR_W-1:0]  cell_attr
);

    import tcw_pkg::*;

    localparam int CELLS  = ROWS * COLUMNS;
    localparam int COPY_N = (ROWS - 1) * COLUMNS;
    localparam int CW     = $clog2(COLUMNS);
    localparam int RW     = $clog2(ROWS);
    localparam int AW     = $clog2(CELLS);
    localparam int SW     = $clog2(CELLS + 1);

    localparam logic [CW-1:0] LAST_COL = CW'(COLUMNS - 1);
    localparam logic [RW-1:0] LAST_ROW = RW'(ROWS - 1);

    function automatic logic [AW-1:0] cell_addr(input logic [RW-1:0] r,
                                                input logic [CW-1:0] c);
        return AW'(AW'(r) * AW'(COLUMNS) + AW'(c));
    endfunction

    tcw_state_t          state_reg, state_next;
    logic [SW-1:0]       sweep_reg, sweep_next;
    logic [CW-1:0]       col_reg, col_next;
    logic [RW-1:0]       row_reg, row_next;
    logic [ATTR_W-1:0]   attr_reg;
    logic [KIND_W-1:0]   kind_reg, kind_next;
    logic                result_valid_reg, result_valid_next;
    logic [COL_W-1:0]    out_col_reg;
    logic [ROW_W-1:0]    out_row_reg;
    logic [CHAR_W-1:0]   out_char_reg;
    logic [ATTR_W-1:0]   out_attr_reg;
    logic                result_load;

    logic                item_accept;
    logic [CW-1:0]       tcol_clamped;
    logic [RW-1:0]       trow_clamped;
    logic [SW-1:0]       sweep_src;
    logic [SW-1:0]       sweep_dst;

    logic                mem_we;
    logic [AW-1:0]       mem_waddr;
    logic [CELL_W-1:0]   mem_wdata;
    logic                mem_re;
    logic [AW-1:0]       mem_raddr;
    logic [CELL_W-1:0]   mem_rdata;

    tcw_ram #(
        .WIDTH (CELL_W),
        .DEPTH (CELLS)
    ) u_screen (
        .clk   (clk),
        .we    (mem_we),
        .waddr (mem_waddr),
        .wdata (mem_wdata),
        .re    (mem_re),
        .raddr (mem_raddr),
        .rdata (mem_rdata)
    );

    assign cfg_ready   = 1'b1;
    assign item_stall  = (state_reg != ST_IDLE);
    assign item_accept = item_valid && !item_stall;

    assign tcol_clamped = (target_col > COL_W'(COLUMNS - 1)) ? LAST_COL : CW'(target_col);
    assign trow_clamped = (int'(target_row) > ROWS - 1) ? LAST_ROW : RW'(target_row);

    // Scroll copies cell k+COLUMNS to cell k, each write landing in the cycle after its read
    assign sweep_src = sweep_reg + SW'(COLUMNS);
    assign sweep_dst = sweep_reg - SW'(1);

    always_comb
    begin
        state_next = state_reg;
        sweep_next = sweep_reg;
        col_next   = col_reg;
        row_next   = row_reg;
        kind_next  = kind_reg;
        mem_we     = 1'b0;
        mem_waddr  = '0;
        mem_wdata  = '0;
        mem_re     = 1'b0;
        mem_raddr  = '0;
        result_load = 1'b0;

        case (state_reg)
            ST_INIT:
            begin
                mem_we    = 1'b1;
                mem_waddr = sweep_reg[AW-1:0];
                mem_wdata = {RESET_ATTR, CODE_SPACE};
                if (sweep_reg == SW'(CELLS - 1))
                begin
                    sweep_next = '0;
                    state_next = ST_IDLE;
                end
                else
                begin
                    sweep_next = sweep_reg + SW'(1);
                end
            end

            ST_IDLE:
            begin
                if (item_accept)
                begin
                    kind_next  = kind;
                    sweep_next = '0;
                    state_next = ST_RESULT;
                    case (kind)
                        KIND_PUT:
                        begin
                            if (!(char_code inside {CODE_LF, CODE_CR}))
                            begin
                                mem_we    = 1'b1;
                                mem_waddr = cell_addr(row_reg, col_reg);
                                mem_wdata = {attr_reg, char_code};
                            end
                            if ((char_code inside {CODE_LF, CODE_CR}) || col_reg == LAST_COL)
                            begin
                                col_next = '0;
                                // bottom row: scroll and stay on the last row
                                if (row_reg == LAST_ROW)
                                begin
                                    state_next = ST_SCROLL;
                                end
                                else
                                begin
                                    row_next = row_reg + RW'(1);
                                end
                            end
                            else
                            begin
                                col_next = col_reg + CW'(1);
                            end
                        end
                        KIND_CLEAR:
                        begin
                            col_next   = '0;
                            row_next   = '0;
                            state_next = ST_FILL;
                        end
                        KIND_SETPOS:
                        begin
                            col_next = tcol_clamped;
                            row_next = trow_clamped;
                        end
                        KIND_READ:
                        begin
                            mem_re    = 1'b1;
                            mem_raddr = cell_addr(trow_clamped, tcol_clamped);
                        end
                        default:
                        begin
                            state_next = ST_RESULT;
                        end
                    endcase
                end
            end

            ST_FILL:
            begin
                mem_we    = 1'b1;
                mem_waddr = sweep_reg[AW-1:0];
                mem_wdata = {attr_reg, CODE_SPACE};
                if (sweep_reg == SW'(CELLS - 1))
                begin
                    sweep_next = '0;
                    state_next = ST_RESULT;
                end
                else
                begin
                    sweep_next = sweep_reg + SW'(1);
                end
            end

            ST_SCROLL:
            begin
                if (sweep_reg < SW'(COPY_N))
                begin
                    mem_re    = 1'b1;
                    mem_raddr = sweep_src[AW-1:0];
                end
                if (sweep_reg != '0)
                begin
                    mem_we    = 1'b1;
                    mem_waddr = sweep_dst[AW-1:0];
                    // bottom row is zeroed once the copy has passed it
                    mem_wdata = (sweep_reg <= SW'(COPY_N)) ? mem_rdata : '0;
                end
                if (sweep_reg == SW'(CELLS))
                begin
                    sweep_next = '0;
                    state_next = ST_RESULT;
                end
                else
                begin
                    sweep_next = sweep_reg + SW'(1);
                end
            end

            ST_RESULT:
            begin
                if (!result_valid_reg || !result_stall)
                begin
                    result_load = 1'b1;
                    state_next  = ST_IDLE;
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        result_valid_next = result_valid_reg && result_stall;
        if (result_load)
        begin
            result_valid_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= ST_INIT;
            sweep_reg        <= '0;
            col_reg          <= '0;
            row_reg          <= '0;
            attr_reg         <= RESET_ATTR;
            result_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg        <= state_next;
            sweep_reg        <= sweep_next;
            col_reg          <= col_next;
            row_reg          <= row_next;
            result_valid_reg <= result_valid_next;
            if (cfg_valid && cfg_ready)
            begin
                attr_reg <= text_attribute;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        kind_reg <= kind_next;
        if (result_load)
        begin
            out_col_reg <= COL_W'(col_reg);
            out_row_reg <= ROW_W'(row_reg);
            if (kind_reg == KIND_READ)
            begin
                out_char_reg <= mem_rdata[CHAR_W-1:0];
                out_attr_reg <= mem_rdata[CELL_W-1:CHAR_W];
            end
            else
            begin
                out_char_reg <= '0;
                out_attr_reg <= '0;
            end
        end
    end

    assign result_valid = result_valid_reg;
    assign cursor_col   = out_col_reg;
    assign cursor_row   = out_row_reg;
    assign cell_char    = out_char_reg;
    assign cell_attr    = out_attr_reg;

    `TCW_ASSERT_NEVER(a_cursor_on_screen, col_reg > LAST_COL || row_reg > LAST_ROW, "cursor left the screen")
    `TCW_ASSERT_CLK(a_result_from_seq, $rose(result_valid_reg) |-> $past(state_reg == ST_RESULT), "result raised outside result step")
    `TCW_ASSERT_CLK(a_scroll_on_last_row, state_reg == ST_SCROLL |-> row_reg == LAST_ROW && col_reg == '0, "scroll with cursor off last row start")
    `TCW_ASSERT_CLK(a_fill_homed, state_reg == ST_FILL |-> row_reg == '0 && col_reg == '0, "clear without cursor home")
    `TCW_ASSERT_NEVER(a_no_write_in_result, mem_we && state_reg == ST_RESULT, "screen write while delivering result")

endmodule

// ===== tb/sv/text_console_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// text_console_checker: screen and cursor predictor for the console writer
// Watches the attribute, item and result channels, keeps its own copy of the
// character store, cursor and attribute, and compares each result beat with
// the oldest predicted view. Hands the mismatch count and the number of
// results still owed to the testbench top.
// ----------------------------------------------------------------------------

module text_console_checker #(
    parameter int COLUMNS = tcw_pkg::DEF_COLUMNS,
    parameter int ROWS    = tcw_pkg::DEF_ROWS
) (
    input  logic                        clk,
    input  logic                        rst_n,

    input  logic                        cfg_valid,
    input  logic                        cfg_ready,
    input  logic [tcw_pkg::ATTR_W-1:0]  text_attribute,

    input  logic                        item_valid,
    input  logic                        item_stall,
    input  logic [tcw_pkg::KIND_W-1:0]  kind,
    input  logic [tcw_pkg::CHAR_W-1:0]  char_code,
    input  logic [tcw_pkg::COL_W-1:0]   target_col,
    input  logic [tcw_pkg::ROW_W-1:0]   target_row,

    input  logic                        result_valid,
    input  logic                        result_stall,
    input  logic [tcw_pkg::COL_W-1:0]   cursor_col,
    input  logic [tcw_pkg::ROW_W-1:0]   cursor_row,
    input  logic [tcw_pkg::CHAR_W-1:0]  cell_char,
    input  logic [tcw_pkg::ATTR_W-1:0]  cell_attr,

    output int                          mismatches,
    output int                          outstanding
);

    import tcw_pkg::*;

    typedef struct packed {
        logic [COL_W-1:0]  col;
        logic [ROW_W-1:0]  row;
        logic [CHAR_W-1:0] ch;
        logic [ATTR_W-1:0] attr;
    } console_view_t;

    logic [CELL_W-1:0] screen [ROWS][COLUMNS];
    int                cur_col;
    int                cur_row;
    logic [ATTR_W-1:0] attr_reg;
    console_view_t     expected_views [$];

    task automatic fill_screen(input logic [CELL_W-1:0] fill_value);
        for (int r = 0; r < ROWS; r++)
            for (int c = 0; c < COLUMNS; c++)
                screen[r][c] = fill_value;
    endtask

    task automatic apply_console_item(
        input  logic [KIND_W-1:0] k,
        input  logic [CHAR_W-1:0] ch,
        input  logic [COL_W-1:0]  tcol,
        input  logic [ROW_W-1:0]  trow,
        output console_view_t     view
    );
        int col_c;
        int row_c;
        col_c = (int'(tcol) > COLUMNS - 1) ? COLUMNS - 1 : int'(tcol);
        row_c = (int'(trow) > ROWS - 1) ? ROWS - 1 : int'(trow);
        view  = '0;
        case (k)
            KIND_PUT:
            begin
                if (ch == CODE_LF || ch == CODE_CR)
                begin
                    cur_col = 0;
                    cur_row++;
                end
                else
                begin
                    screen[cur_row][cur_col] = {attr_reg, ch};
                    cur_col++;
                    if (cur_col >= COLUMNS)
                    begin
                        cur_col = 0;
                        cur_row++;
                    end
                end
                // scroll up one row and zero the bottom row
                if (cur_row >= ROWS)
                begin
                    for (int r = 0; r < ROWS - 1; r++)
                        for (int c = 0; c < COLUMNS; c++)
                            screen[r][c] = screen[r + 1][c];
                    for (int c = 0; c < COLUMNS; c++)
                        screen[ROWS - 1][c] = '0;
                    cur_row = ROWS - 1;
                end
            end
            KIND_CLEAR:
            begin
                fill_screen({attr_reg, CODE_SPACE});
                cur_col = 0;
                cur_row = 0;
            end
            KIND_SETPOS:
            begin
                cur_col = col_c;
                cur_row = row_c;
            end
            default:
            begin
                view.ch   = screen[row_c][col_c][CHAR_W-1:0];
                view.attr = screen[row_c][col_c][CELL_W-1:CHAR_W];
            end
        endcase
        view.col = cur_col[COL_W-1:0];
        view.row = cur_row[ROW_W-1:0];
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        console_view_t want;
        console_view_t got;
        if (!rst_n)
        begin
            fill_screen({RESET_ATTR, CODE_SPACE});
            cur_col     = 0;
            cur_row     = 0;
            attr_reg    = RESET_ATTR;
            expected_views.delete();
            mismatches  = 0;
            outstanding = 0;
        end
        else
        begin
            if (cfg_valid && cfg_ready)
                attr_reg = text_attribute;

            if (item_valid && !item_stall)
            begin
                apply_console_item(kind, char_code, target_col, target_row, want);
                expected_views.push_back(want);
            end

            if (result_valid && !result_stall)
            begin
                got = '{col: cursor_col, row: cursor_row, ch: cell_char, attr: cell_attr};
                if (expected_views.size() == 0)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("[%0t] unexpected beat: col %0d row %0d char %02h attr %02h",
                                 $realtime, got.col, got.row, got.ch, got.attr);
                end
                else
                begin
                    want = expected_views.pop_front();
                    if (got.col != want.col || got.row != want.row ||
                        got.ch != want.ch || got.attr != want.attr)
                    begin
                        mismatches++;
                        if (mismatches <= 10)
                            $display("[%0t] mismatch: exp %0d/%0d %02h/%02h got %0d/%0d %02h/%02h",
                                     $realtime, want.col, want.row, want.ch, want.attr,
                                     got.col, got.row, got.ch, got.attr);
                    end
                end
            end

            outstanding = expected_views.size();
        end
    end

endmodule

// ===== tb/sv/tb_text_console_writer.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_text_console_writer: regression bench for the text console writer
// Drives directed put, line break, wrap, scroll, clear, set-cursor and read
// items, then random phases of text runs, reads, cursor moves and clears under
// several attributes, with random gaps on the item side and random stalls on
// the result side. The checker beside the block predicts every result.
// ----------------------------------------------------------------------------

module tb_text_console_writer;
    import tcw_pkg::*;

    localparam int ITEM_TARGET    = 1420;
    localparam int PHASE_ITEMS    = 150;
    localparam int WATCHDOG_LIMIT = 12000;
    localparam int COLUMNS_MAX    = DEF_COLUMNS - 1;
    localparam int ROWS_MAX       = DEF_ROWS - 1;

    logic              clk;
    logic              rst_n;
    logic              cfg_valid;
    logic              cfg_ready;
    logic [ATTR_W-1:0] text_attribute;
    logic              item_valid;
    logic              item_stall;
    logic [KIND_W-1:0] kind;
    logic [CHAR_W-1:0] char_code;
    logic [COL_W-1:0]  target_col;
    logic [ROW_W-1:0]  target_row;
    logic              result_valid;
    logic              result_stall;
    logic [COL_W-1:0]  cursor_col;
    logic [ROW_W-1:0]  cursor_row;
    logic [CHAR_W-1:0] cell_char;
    logic [ATTR_W-1:0] cell_attr;

    int mismatches;
    int outstanding;
    int items_sent;
    int stall_left;
    bit no_idle;

    text_console_writer DUT (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg_valid      (cfg_valid),
        .cfg_ready      (cfg_ready),
        .text_attribute (text_attribute),
        .item_valid     (item_valid),
        .item_stall     (item_stall),
        .kind           (kind),
        .char_code      (char_code),
        .target_col     (target_col),
        .target_row     (target_row),
        .result_valid   (result_valid),
        .result_stall   (result_stall),
        .cursor_col     (cursor_col),
        .cursor_row     (cursor_row),
        .cell_char      (cell_char),
        .cell_attr      (cell_attr)
    );

    text_console_checker u_checker (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg_valid      (cfg_valid),
        .cfg_ready      (cfg_ready),
        .text_attribute (text_attribute),
        .item_valid     (item_valid),
        .item_stall     (item_stall),
        .kind           (kind),
        .char_code      (char_code),
        .target_col     (target_col),
        .target_row     (target_row),
        .result_valid   (result_valid),
        .result_stall   (result_stall),
        .cursor_col     (cursor_col),
        .cursor_row     (cursor_row),
        .cell_char      (cell_char),
        .cell_attr      (cell_attr),
        .mismatches     (mismatches),
        .outstanding    (outstanding)
    );

    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    // mostly short gaps, a few long ones
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (no_idle || r < 50)
            return 0;
        else if (r < 85)
            return $urandom_range(1, 3);
        else if (r < 97)
            return $urandom_range(4, 10);
        else
            return $urandom_range(20, 60);
    endfunction

    // result-side stalls, updated on the falling edge
    always @(negedge clk)
    begin
        if (!rst_n)
        begin
            result_stall <= 1'b0;
            stall_left   <= 0;
        end
        else if (stall_left != 0)
        begin
            result_stall <= 1'b1;
            stall_left   <= stall_left - 1;
        end
        else
        begin
            result_stall <= 1'b0;
            if ($urandom_range(0, 3) == 0)
                stall_left <= pick_gap();
        end
    end

    // called at a falling edge; returns at the falling edge after the beat
    task automatic send_item(
        input logic [KIND_W-1:0] k,
        input logic [CHAR_W-1:0] ch,
        input logic [COL_W-1:0]  tcol,
        input logic [ROW_W-1:0]  trow
    );
        int gap;
        gap = pick_gap();
        if (gap > 0)
        begin
            item_valid = 1'b0;
            repeat (gap) @(negedge clk);
        end
        kind       = k;
        char_code  = ch;
        target_col = tcol;
        target_row = trow;
        item_valid = 1'b1;
        do
            @(posedge clk);
        while (item_stall);
        @(negedge clk);
        items_sent++;
    endtask

    // write the attribute only once every owed result has come back
    task automatic write_attribute(input logic [ATTR_W-1:0] value);
        item_valid = 1'b0;
        while (outstanding != 0)
            @(negedge clk);
        repeat (4) @(negedge clk);
        text_attribute = value;
        cfg_valid      = 1'b1;
        do
            @(posedge clk);
        while (!cfg_ready);
        @(negedge clk);
        cfg_valid = 1'b0;
    endtask

    task automatic run_scenario();
        int pick;
        int n;
        logic [CHAR_W-1:0] ch;
        pick = $urandom_range(0, 99);
        if (pick < 50)
        begin
            // text run with occasional line breaks
            n = $urandom_range(1, 30);
            repeat (n)
            begin
                if ($urandom_range(0, 15) == 0)
                    ch = $urandom_range(0, 1) ? CODE_LF : CODE_CR;
                else
                    ch = CHAR_W'($urandom_range(0, 255));
                send_item(KIND_PUT, ch, COL_W'($urandom_range(0, 127)),
                          ROW_W'($urandom_range(0, 31)));
            end
        end
        else if (pick < 78)
        begin
            n = $urandom_range(1, 6);
            repeat (n)
                send_item(KIND_READ, CHAR_W'($urandom_range(0, 255)),
                          COL_W'($urandom_range(0, 127)), ROW_W'($urandom_range(0, 31)));
        end
        else if (pick < 97)
        begin
            // bias toward the bottom-right corner to provoke wrap and scroll
            if ($urandom_range(0, 3) == 0)
                send_item(KIND_SETPOS, CHAR_W'($urandom_range(0, 255)),
                          COL_W'($urandom_range(COLUMNS_MAX - 9, COLUMNS_MAX)),
                          ROW_W'($urandom_range(ROWS_MAX - 2, ROWS_MAX)));
            else
                send_item(KIND_SETPOS, CHAR_W'($urandom_range(0, 255)),
                          COL_W'($urandom_range(0, 127)), ROW_W'($urandom_range(0, 31)));
        end
        else
        begin
            send_item(KIND_CLEAR, CHAR_W'($urandom_range(0, 255)),
                      COL_W'($urandom_range(0, 127)), ROW_W'($urandom_range(0, 31)));
        end
    endtask

    initial
    begin
        int phase;
        int phase_end;
        rst_n          = 1'b0;
        cfg_valid      = 1'b0;
        text_attribute = '0;
        item_valid     = 1'b0;
        kind           = KIND_PUT;
        char_code      = '0;
        target_col     = '0;
        target_row     = '0;
        items_sent     = 0;
        no_idle        = 1'b0;
        repeat (6) @(negedge clk);
        rst_n = 1'b1;

        // reset contents, clamped reads, puts and line breaks
        send_item(KIND_READ, 8'h00, 7'd0, 5'd0);
        send_item(KIND_READ, 8'hFF, 7'd127, 5'd31);
        send_item(KIND_PUT, 8'h41, 7'd0, 5'd0);
        send_item(KIND_PUT, 8'h00, 7'd127, 5'd31);
        send_item(KIND_PUT, 8'hFF, 7'd0, 5'd0);
        send_item(KIND_READ, 8'h00, 7'd0, 5'd0);
        send_item(KIND_PUT, CODE_LF, 7'd0, 5'd0);
        send_item(KIND_PUT, CODE_CR, 7'd0, 5'd0);
        // wrap on the last cell scrolls the screen
        send_item(KIND_SETPOS, 8'h00, 7'd127, 5'd31);
        send_item(KIND_PUT, 8'h5A, 7'd0, 5'd0);
        send_item(KIND_READ, 8'h00, 7'd79, 5'd23);
        send_item(KIND_READ, 8'h00, 7'd0, 5'd24);
        send_item(KIND_PUT, CODE_LF, 7'd0, 5'd0);
        send_item(KIND_READ, 8'h00, 7'd79, 5'd22);
        send_item(KIND_SETPOS, 8'h00, 7'd78, 5'd5);
        send_item(KIND_PUT, 8'h78, 7'd0, 5'd0);
        send_item(KIND_PUT, 8'h79, 7'd0, 5'd0);
        send_item(KIND_READ, 8'h00, 7'd79, 5'd5);

        write_attribute(8'hA5);
        send_item(KIND_PUT, 8'h21, 7'd0, 5'd0);
        send_item(KIND_CLEAR, 8'h00, 7'd0, 5'd0);
        send_item(KIND_READ, 8'h00, 7'd40, 5'd12);
        send_item(KIND_PUT, 8'h7E, 7'd0, 5'd0);
        send_item(KIND_READ, 8'h00, 7'd0, 5'd0);

        phase = 0;
        while (items_sent < ITEM_TARGET)
        begin
            if (phase == 0)
                write_attribute(8'h00);
            else if (phase == 1)
                write_attribute(8'hFF);
            else
                write_attribute(ATTR_W'($urandom_range(0, 255)));
            no_idle   = ($urandom_range(0, 3) == 0);
            phase_end = items_sent + PHASE_ITEMS;
            while (items_sent < phase_end && items_sent < ITEM_TARGET)
                run_scenario();
            phase++;
        end
        item_valid = 1'b0;
        no_idle    = 1'b0;

        while (outstanding != 0)
            @(negedge clk);
        repeat (16) @(negedge clk);

        if (mismatches == 0)
            $display("text_console_writer regression: pass");
        else
            $display("text_console_writer regression: fail");
        $finish;
    end

    // end the run if no beat moves on any channel for too long
    initial
    begin
        int quiet_cycles;
        quiet_cycles = 0;
        while (quiet_cycles < WATCHDOG_LIMIT)
        begin
            @(posedge clk);
            if ((item_valid && !item_stall) || (result_valid && !result_stall) ||
                (cfg_valid && cfg_ready))
                quiet_cycles = 0;
            else
                quiet_cycles++;
        end
        $display("text_console_writer regression: fail");
        $finish;
    end

endmodule
